FILE: src/gsr_pkg.sv
// Shared types and constants for the grip slip reflex detector.
// Word formats, operation and register codes, and reset values.
// No dependencies; every other file in src except gsr_fifo uses this package.
package gsr_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int FINGERS_DEF       = 5;
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int FORCE_BITS_DEF    = 12;

  // Queue depths between the stages and at the result side.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Width of the force field as it travels between stages.
  localparam int FORCE_W = 12;

  // Input kinds. The spare kind is accepted and does nothing.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_MANUAL = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLED      = 3'd0;
  localparam logic [2:0] CFG_FINGER_COUNT = 3'd1;
  localparam logic [2:0] CFG_DROP_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_MIN_FORCE    = 3'd3;
  localparam logic [2:0] CFG_COOLDOWN_MS  = 3'd4;

  // Configuration reset values.
  localparam logic        ENABLED_RST      = 1'b1;
  localparam logic [2:0]  FINGER_COUNT_RST = 3'd5;
  localparam logic [11:0] DROP_LIMIT_RST   = 12'd200;
  localparam logic [11:0] MIN_FORCE_RST    = 12'd100;
  localparam logic [15:0] COOLDOWN_MS_RST  = 16'd50;

  // Operation decided by the front stage for the back stage.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_TICK,
    OP_MANUAL
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  finger;
    logic [11:0] force_req;
  } in_word_t;

  typedef struct packed {
    logic        reflex_fired;
    logic [2:0]  reflex_finger;
    logic        manual;
    logic [31:0] reflex_total;
  } out_word_t;

  typedef struct packed {
    op_t                op;
    logic [2:0]         finger;
    logic [FORCE_W-1:0] force_val;
    logic [FORCE_W-1:0] oldest_val;
  } mid_word_t;

endpackage

FILE: src/grip_slip_reflex_detector.sv
// Top level of the per-finger grip slip reflex detector.
// Holds the configuration registers and joins front, queues and back.
// Depends on gsr_pkg, gsr_fifo, gsr_front and gsr_back.
//
// Input words (force sample, millisecond tick, manual reflex) are pushed
// with push while full is low. Every input word yields exactly one result
// word, which waits on out_data while empty is low and leaves on pop.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data, one register per cycle. The user must write them only while
// the block is idle; the block itself does not enforce this.
// Each word passes the front register and the middle queue; the back stage
// then pushes its result word into the result queue that drives out_data.
// One word per cycle is sustained while the result queue does not fill:
// each word reads the force ring memory in its accept cycle, a sample that
// is taken also writes it, and the back stage finishes one word per cycle.
// The front register plus a 4-word queue feed the back stage; full rises
// when those hold 4 words. If pop stays low, the 2-word result queue fills,
// the back stage stops, and full follows once the middle queue fills up.
// Reset clears the queues, the ring pointers, the clock, the count and the
// last reflex times, and loads the register defaults. No clearing pass is
// needed: unwritten ring slots read as zero through the fill tracking.
module grip_slip_reflex_detector #(
  parameter int FINGERS       = gsr_pkg::FINGERS_DEF,
  parameter int HISTORY_DEPTH = gsr_pkg::HISTORY_DEPTH_DEF,
  parameter int FORCE_BITS    = gsr_pkg::FORCE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gsr_pkg::in_word_t  in_data,
  output logic               empty,
  input  logic               pop,
  output gsr_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int MIDW = $bits(gsr_pkg::mid_word_t);
  localparam int OUTW = $bits(gsr_pkg::out_word_t);

  logic        enabled;
  logic [2:0]  finger_count;
  logic [11:0] drop_limit;
  logic [11:0] min_force;
  logic [15:0] cooldown_ms;

  logic                                     mid_push;
  gsr_pkg::mid_word_t                       mid_in;
  logic [MIDW-1:0]                          mid_rdata;
  logic                                     mid_empty;
  logic                                     mid_pop;
  logic [$clog2(gsr_pkg::MID_DEPTH+1)-1:0]  mid_count;
  logic                                     out_push;
  gsr_pkg::out_word_t                       out_in;
  logic [OUTW-1:0]                          out_rdata;
  logic [$clog2(gsr_pkg::OUT_DEPTH+1)-1:0]  out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= gsr_pkg::ENABLED_RST;
      finger_count <= gsr_pkg::FINGER_COUNT_RST;
      drop_limit   <= gsr_pkg::DROP_LIMIT_RST;
      min_force    <= gsr_pkg::MIN_FORCE_RST;
      cooldown_ms  <= gsr_pkg::COOLDOWN_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gsr_pkg::CFG_ENABLED:      enabled      <= cfg_data[0];
        gsr_pkg::CFG_FINGER_COUNT: finger_count <= cfg_data[2:0];
        gsr_pkg::CFG_DROP_LIMIT:   drop_limit   <= cfg_data[11:0];
        gsr_pkg::CFG_MIN_FORCE:    min_force    <= cfg_data[11:0];
        gsr_pkg::CFG_COOLDOWN_MS:  cooldown_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  gsr_front #(
    .FINGERS       (FINGERS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .FORCE_BITS    (FORCE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .in_data      (in_data),
    .full         (full),
    .enabled      (enabled),
    .finger_count (finger_count),
    .mid_count    (mid_count),
    .mid_push     (mid_push),
    .mid_data     (mid_in)
  );

  gsr_fifo #(
    .WIDTH (MIDW),
    .DEPTH (gsr_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  gsr_back #(
    .FINGERS (FINGERS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mid_empty   (mid_empty),
    .mid_data    (gsr_pkg::mid_word_t'(mid_rdata)),
    .mid_pop     (mid_pop),
    .out_count   (out_count),
    .out_push    (out_push),
    .out_data    (out_in),
    .drop_limit  (drop_limit),
    .min_force   (min_force),
    .cooldown_ms (cooldown_ms)
  );

  gsr_fifo #(
    .WIDTH (OUTW),
    .DEPTH (gsr_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_in),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign out_data = gsr_pkg::out_word_t'(out_rdata);

endmodule

FILE: src/gsr_fifo.sv
// Small first-in first-out queue of flat words.
// Used between the front and back stages and at the result side.
// Depends on nothing but its parameters.
module gsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && (count != CW'(DEPTH));
  assign do_pop  = pop && (count != '0);
  assign empty   = (count == '0);
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/gsr_front.sv
// Front stage: accepts input words, classifies them, keeps the force rings.
// Writes the new reading and reads the oldest one from the ring memory.
// Depends on gsr_pkg.
module gsr_front #(
  parameter int FINGERS       = gsr_pkg::FINGERS_DEF,
  parameter int HISTORY_DEPTH = gsr_pkg::HISTORY_DEPTH_DEF,
  parameter int FORCE_BITS    = gsr_pkg::FORCE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  gsr_pkg::in_word_t                     in_data,
  output logic                                  full,
  input  logic                                  enabled,
  input  logic [2:0]                            finger_count,
  input  logic [$clog2(gsr_pkg::MID_DEPTH+1)-1:0] mid_count,
  output logic                                  mid_push,
  output gsr_pkg::mid_word_t                    mid_data
);

  localparam int FIDX    = (FINGERS > 1) ? $clog2(FINGERS) : 1;
  localparam int PW      = $clog2(HISTORY_DEPTH);
  localparam int ENTRIES = FINGERS * HISTORY_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MCW     = $clog2(gsr_pkg::MID_DEPTH + 1);
  localparam logic [gsr_pkg::FORCE_W-1:0] FORCE_MASK =
    gsr_pkg::FORCE_W'((64'd1 << FORCE_BITS) - 64'd1);

  logic [FORCE_BITS-1:0] ring [ENTRIES];
  logic [PW-1:0]         pointer [FINGERS];
  logic [FINGERS-1:0]    wrapped;

  logic                          fv;
  gsr_pkg::op_t                  f_op;
  logic [2:0]                    f_finger;
  logic [gsr_pkg::FORCE_W-1:0]   f_force;
  logic                          f_ovalid;
  logic [FORCE_BITS-1:0]         rd_word;

  logic                          accept;
  logic [4:0]                    limit;
  logic                          in_use;
  logic [FIDX-1:0]               idx;
  logic [PW-1:0]                 p;
  logic [PW-1:0]                 q;
  logic [AW-1:0]                 wa;
  logic [AW-1:0]                 ra;
  logic [gsr_pkg::FORCE_W-1:0]   force_m;
  gsr_pkg::op_t                  op;
  logic                          write_ring;
  logic                          old_valid;

  // One slot is held back for the word sitting in the front register.
  assign full = ({1'b0, mid_count} + (MCW + 1)'(fv)) >= (MCW + 1)'(gsr_pkg::MID_DEPTH);
  assign accept = push && !full;

  assign limit   = (5'(finger_count) < 5'(FINGERS)) ? 5'(finger_count) : 5'(FINGERS);
  assign in_use  = 5'(in_data.finger) < limit;
  assign idx     = FIDX'(in_data.finger);
  assign p       = pointer[idx];
  assign q       = (p == PW'(HISTORY_DEPTH - 1)) ? '0 : p + PW'(1);
  assign wa      = AW'(int'(idx) * HISTORY_DEPTH + int'(p));
  assign ra      = AW'(int'(idx) * HISTORY_DEPTH + int'(q));
  assign force_m = in_data.force_req & FORCE_MASK;

  // Slots fill in order from zero, so the next slot holds a reading only
  // once the ring has wrapped or the pointer is about to wrap.
  assign old_valid = wrapped[idx] || (q < p);

  always_comb begin
    case (in_data.kind)
      gsr_pkg::KIND_SAMPLE: op = (enabled && in_use) ? gsr_pkg::OP_SAMPLE : gsr_pkg::OP_NONE;
      gsr_pkg::KIND_TICK:   op = gsr_pkg::OP_TICK;
      gsr_pkg::KIND_MANUAL: op = in_use ? gsr_pkg::OP_MANUAL : gsr_pkg::OP_NONE;
      default:              op = gsr_pkg::OP_NONE;
    endcase
  end

  assign write_ring = accept && (op == gsr_pkg::OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (write_ring) begin
      ring[wa] <= FORCE_BITS'(force_m);
    end
    rd_word <= ring[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FINGERS; i++) begin
        pointer[i] <= '0;
      end
      wrapped <= '0;
      fv      <= 1'b0;
    end else begin
      fv <= accept;
      if (write_ring) begin
        pointer[idx] <= q;
        if (q == '0) begin
          wrapped[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op     <= op;
      f_finger <= in_data.finger;
      f_force  <= force_m;
      f_ovalid <= old_valid;
    end
  end

  assign mid_push            = fv;
  assign mid_data.op         = f_op;
  assign mid_data.finger     = f_finger;
  assign mid_data.force_val  = f_force;
  assign mid_data.oldest_val = f_ovalid ? gsr_pkg::FORCE_W'(rd_word) : '0;

endmodule

FILE: src/gsr_back.sv
// Back stage: slip test, cooldown, millisecond clock and reflex count.
// Takes classified words from the middle queue and pushes result words.
// Depends on gsr_pkg.
module gsr_back #(
  parameter int FINGERS = gsr_pkg::FINGERS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  mid_empty,
  input  gsr_pkg::mid_word_t                    mid_data,
  output logic                                  mid_pop,
  input  logic [$clog2(gsr_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic                                  out_push,
  output gsr_pkg::out_word_t                    out_data,
  input  logic [11:0]                           drop_limit,
  input  logic [11:0]                           min_force,
  input  logic [15:0]                           cooldown_ms
);

  localparam int FIDX = (FINGERS > 1) ? $clog2(FINGERS) : 1;
  localparam int OCW  = $clog2(gsr_pkg::OUT_DEPTH + 1);

  logic [31:0] time_ms;
  logic [31:0] reflex_counter;
  logic [31:0] last_reflex_time [FINGERS];

  logic                        go;
  logic [FIDX-1:0]             idx;
  logic [31:0]                 elapsed;
  logic [gsr_pkg::FORCE_W-1:0] drop;
  logic                        slip;
  logic                        fire;
  logic                        manual;
  logic [31:0]                 total_inc;

  assign go      = !mid_empty && (out_count != OCW'(gsr_pkg::OUT_DEPTH));
  assign mid_pop = go;
  assign idx     = FIDX'(mid_data.finger);

  // Elapsed time wraps with the clock, so the subtraction is modulo 2^32.
  assign elapsed = time_ms - last_reflex_time[idx];
  assign drop    = mid_data.oldest_val - mid_data.force_val;
  assign slip    = (elapsed >= 32'(cooldown_ms)) &&
                   (mid_data.force_val >= min_force) &&
                   (mid_data.oldest_val > mid_data.force_val) &&
                   (drop > drop_limit);
  assign total_inc = reflex_counter + 32'd1;

  always_comb begin
    case (mid_data.op)
      gsr_pkg::OP_SAMPLE: begin
        fire   = slip;
        manual = 1'b0;
      end
      gsr_pkg::OP_MANUAL: begin
        fire   = 1'b1;
        manual = 1'b1;
      end
      default: begin
        fire   = 1'b0;
        manual = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms        <= '0;
      reflex_counter <= '0;
      for (int i = 0; i < FINGERS; i++) begin
        last_reflex_time[i] <= '0;
      end
    end else if (go) begin
      if (mid_data.op == gsr_pkg::OP_TICK) begin
        time_ms <= time_ms + 32'd1;
      end
      if (fire) begin
        last_reflex_time[idx] <= time_ms;
        reflex_counter        <= total_inc;
      end
    end
  end

  assign out_push               = go;
  assign out_data.reflex_fired  = fire;
  assign out_data.reflex_finger = fire ? mid_data.finger : 3'd0;
  assign out_data.manual        = manual;
  assign out_data.reflex_total  = fire ? total_inc : reflex_counter;

endmodule

FILE: src/gsr_checker.sv
// Port-level checks for the grip slip reflex detector, bound to the top.
// Tracks words in flight and the last delivered reflex total.
// Depends on gsr_pkg and grip_slip_reflex_detector.
module gsr_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input gsr_pkg::out_word_t out_data
);

  logic [7:0]  outstanding;
  logic [31:0] last_total;
  logic        in_acc;
  logic        out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      last_total  <= '0;
    end else begin
      outstanding <= outstanding + 8'(in_acc) - 8'(out_acc);
      if (out_acc) begin
        last_total <= out_data.reflex_total;
      end
    end
  end

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // The running count moves by one exactly when a reflex fires.
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_data.reflex_total == last_total + 32'(out_data.reflex_fired))
    else $error("reflex total does not follow the previous word");

  // A word entering an idle block gets its result into the result queue.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (outstanding == 8'd0 && in_acc) |-> ##3 !empty)
    else $error("result late for a word entering an idle block");

  // An idle block never refuses input.
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    outstanding == 8'd0 |-> !full)
    else $error("full while nothing is in flight");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed before pop");

endmodule

bind grip_slip_reflex_detector gsr_checker u_checker (.*);

FILE: test/grip_slip_reflex_detector_tb.sv
// Self-checking testbench for grip_slip_reflex_detector: directed and random words
// against a per-finger slip predictor, under several idle and stall patterns.
// Depends on gsr_pkg and the RTL in src; needs no other files.
module grip_slip_reflex_detector_tb;

  class reflex_scoreboard;
    logic        cfg_enabled  = gsr_pkg::ENABLED_RST;
    logic [2:0]  cfg_fingers  = gsr_pkg::FINGER_COUNT_RST;
    logic [11:0] cfg_drop     = gsr_pkg::DROP_LIMIT_RST;
    logic [11:0] cfg_min      = gsr_pkg::MIN_FORCE_RST;
    logic [15:0] cfg_cooldown = gsr_pkg::COOLDOWN_MS_RST;

    logic [11:0] ring [gsr_pkg::FINGERS_DEF][gsr_pkg::HISTORY_DEPTH_DEF] = '{default: '0};
    int          ring_ptr [gsr_pkg::FINGERS_DEF] = '{default: 0};
    logic [31:0] last_fire_ms [gsr_pkg::FINGERS_DEF] = '{default: '0};
    logic [31:0] clock_ms = '0;
    logic [31:0] reflex_total = '0;

    gsr_pkg::out_word_t expected_q[$];
    int                 errors = 0;

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        gsr_pkg::CFG_ENABLED:      cfg_enabled  = val[0];
        gsr_pkg::CFG_FINGER_COUNT: cfg_fingers  = val[2:0];
        gsr_pkg::CFG_DROP_LIMIT:   cfg_drop     = val[11:0];
        gsr_pkg::CFG_MIN_FORCE:    cfg_min      = val[11:0];
        gsr_pkg::CFG_COOLDOWN_MS:  cfg_cooldown = val;
        default: ;
      endcase
    endfunction

    // Works out the result word that an accepted input word must produce.
    function void note_input(gsr_pkg::in_word_t w);
      gsr_pkg::out_word_t res;
      int                 f;
      int                 span;
      int                 slot;
      logic [11:0]        oldest;
      logic [31:0]        since;
      logic               fire;
      res = '0;
      fire = 1'b0;
      f = w.finger;
      span = (cfg_fingers < gsr_pkg::FINGERS_DEF) ? cfg_fingers : gsr_pkg::FINGERS_DEF;
      case (w.kind)
        gsr_pkg::KIND_SAMPLE: begin
          if (cfg_enabled && f < span) begin
            slot = ring_ptr[f];
            ring[f][slot] = w.force_req;
            slot = (slot + 1) % gsr_pkg::HISTORY_DEPTH_DEF;
            ring_ptr[f] = slot;
            // The slot after the newest one holds the oldest reading.
            oldest = ring[f][slot];
            since = clock_ms - last_fire_ms[f];
            if (since >= {16'd0, cfg_cooldown} && w.force_req >= cfg_min &&
                oldest > w.force_req && (oldest - w.force_req) > cfg_drop) begin
              fire = 1'b1;
            end
          end
        end
        gsr_pkg::KIND_TICK: clock_ms = clock_ms + 1;
        gsr_pkg::KIND_MANUAL: begin
          if (f < span) begin
            fire = 1'b1;
            res.manual = 1'b1;
          end
        end
        default: ;
      endcase
      if (fire) begin
        last_fire_ms[f] = clock_ms;
        reflex_total = reflex_total + 1;
        res.reflex_fired = 1'b1;
        res.reflex_finger = w.finger;
      end
      res.reflex_total = reflex_total;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(gsr_pkg::out_word_t got);
      gsr_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("reflex_fired", want.reflex_fired, got.reflex_fired);
      compare_field("reflex_finger", want.reflex_finger, got.reflex_finger);
      compare_field("manual", want.manual, got.manual);
      compare_field("reflex_total", want.reflex_total, got.reflex_total);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  gsr_pkg::in_word_t  in_data = '0;
  logic               empty;
  logic               pop = 1'b0;
  gsr_pkg::out_word_t out_data;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  reflex_scoreboard sb = new();
  int gap_pct = 0;
  int stall_pct = 0;

  grip_slip_reflex_detector DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && !empty && pop) begin
      sb.check_result(out_data);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic gsr_pkg::in_word_t make_word(logic [1:0] kind, logic [2:0] finger,
                                                  logic [11:0] force_req);
    gsr_pkg::in_word_t w;
    w.kind = kind;
    w.finger = finger;
    w.force_req = force_req;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with push still high, so back-to-back words keep the bus busy.
  task automatic send_word(gsr_pkg::in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic gsr_pkg::in_word_t random_word();
    gsr_pkg::in_word_t w;
    int r;
    r = $urandom_range(99);
    if (r < 60) w.kind = gsr_pkg::KIND_SAMPLE;
    else if (r < 80) w.kind = gsr_pkg::KIND_TICK;
    else if (r < 93) w.kind = gsr_pkg::KIND_MANUAL;
    else w.kind = gsr_pkg::KIND_SPARE;
    w.finger = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    // Mostly high readings with sudden low ones, so drops against the oldest
    // reading in the ring happen often.
    case ($urandom_range(9))
      0: w.force_req = 12'd0;
      1: w.force_req = 12'hFFF;
      2, 3: w.force_req = 12'($urandom_range(0, 4095));
      4, 5: w.force_req = 12'($urandom_range(0, 1200));
      default: w.force_req = 12'($urandom_range(2800, 4095));
    endcase
    return w;
  endfunction

  task automatic configure_random();
    write_reg(gsr_pkg::CFG_ENABLED, ($urandom_range(7) != 0) ? 16'd1 : 16'd0);
    write_reg(gsr_pkg::CFG_FINGER_COUNT,
              ($urandom_range(3) == 0) ? 16'($urandom_range(0, 7)) : 16'd5);
    case ($urandom_range(5))
      0: write_reg(gsr_pkg::CFG_DROP_LIMIT, 16'd0);
      1: write_reg(gsr_pkg::CFG_DROP_LIMIT, 16'($urandom_range(0, 4095)));
      default: write_reg(gsr_pkg::CFG_DROP_LIMIT, 16'($urandom_range(0, 900)));
    endcase
    case ($urandom_range(5))
      0: write_reg(gsr_pkg::CFG_MIN_FORCE, 16'd4095);
      1: write_reg(gsr_pkg::CFG_MIN_FORCE, 16'($urandom_range(0, 4095)));
      default: write_reg(gsr_pkg::CFG_MIN_FORCE, 16'($urandom_range(0, 300)));
    endcase
    case ($urandom_range(7))
      0: write_reg(gsr_pkg::CFG_COOLDOWN_MS, 16'hFFFF);
      1: write_reg(gsr_pkg::CFG_COOLDOWN_MS, 16'($urandom_range(0, 65535)));
      default: write_reg(gsr_pkg::CFG_COOLDOWN_MS, 16'($urandom_range(0, 10)));
    endcase
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: the cooldown is still running from time zero, so a
    // large drop on finger 0 must not fire.
    send_word(make_word(gsr_pkg::KIND_SPARE, 3'd7, 12'hFFF));
    repeat (7) send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd0, 12'hFFF));
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd0, 12'd100));
    send_word(make_word(gsr_pkg::KIND_MANUAL, 3'd0, 12'd0));
    send_word(make_word(gsr_pkg::KIND_MANUAL, 3'd4, 12'd0));
    send_word(make_word(gsr_pkg::KIND_MANUAL, 3'd5, 12'd0));
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd7, 12'd0));
    send_word(make_word(gsr_pkg::KIND_TICK, 3'd0, 12'd0));
    settle();

    write_reg(gsr_pkg::CFG_COOLDOWN_MS, 16'd0);
    write_reg(gsr_pkg::CFG_MIN_FORCE, 16'd0);
    write_reg(gsr_pkg::CFG_DROP_LIMIT, 16'd0);
    write_reg(gsr_pkg::CFG_FINGER_COUNT, 16'd7);
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd0, 12'd0));
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd0, 12'hFFF));
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd4, 12'd0));
    send_word(make_word(gsr_pkg::KIND_MANUAL, 3'd4, 12'hFFF));
    settle();

    write_reg(gsr_pkg::CFG_ENABLED, 16'd0);
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd0, 12'd0));
    send_word(make_word(gsr_pkg::KIND_MANUAL, 3'd1, 12'd0));
    settle();

    write_reg(gsr_pkg::CFG_ENABLED, 16'd1);
    write_reg(gsr_pkg::CFG_DROP_LIMIT, 16'd4095);
    write_reg(gsr_pkg::CFG_MIN_FORCE, 16'd4095);
    write_reg(gsr_pkg::CFG_COOLDOWN_MS, 16'hFFFF);
    write_reg(gsr_pkg::CFG_FINGER_COUNT, 16'd0);
    send_word(make_word(gsr_pkg::KIND_MANUAL, 3'd0, 12'd0));
    send_word(make_word(gsr_pkg::KIND_SAMPLE, 3'd0, 12'hFFF));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      configure_random();
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 80; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 80; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      repeat (107) send_word(random_word());
      settle();
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/gsr_pkg.sv
src/gsr_fifo.sv
src/gsr_front.sv
src/gsr_back.sv
src/grip_slip_reflex_detector.sv
src/gsr_checker.sv
test/grip_slip_reflex_detector_tb.sv
